@@ hw/rtl/jpm_pkg.sv @@
// ---------------------------------------------------------------------------
// jpm_pkg
// Shared widths and constants for the jerk peak and mean unit.
// ---------------------------------------------------------------------------
package jpm_pkg;

  localparam int TIME_W = 32;   // sample timestamp, microseconds
  localparam int ACC_W  = 16;   // Q7.8 acceleration
  localparam int JERK_W = 24;   // jerk, limit, peak and mean
  localparam int SUM_W  = 48;   // running sum of absolute jerk
  localparam int MAG_W  = 16;   // |a_i - a_{i-1}| never exceeds 65535
  localparam int NUM_W  = 38;   // |da| * 2 * 1e6
  localparam int DVD_W  = SUM_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  // 2 * 1e6: halves the time-step sum and converts microseconds to seconds
  localparam logic [20:0] JERK_SCALE = 21'd2000000;

  localparam logic [JERK_W-1:0] MAX_RUN_SAMPLES = 24'hFFFFFF;
  localparam logic [JERK_W-1:0] LIMIT_RESET     = 24'd512;

  localparam logic [CNT_W-1:0] JERK_DIV_STEPS = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] MEAN_DIV_STEPS = CNT_W'(DVD_W);

endpackage

@@ hw/rtl/jpm_in_if.sv @@
// ---------------------------------------------------------------------------
// jpm_in_if
// Sample channel: timestamp, acceleration and end-of-run flag.
// ---------------------------------------------------------------------------
interface jpm_in_if;

  logic                               valid;
  logic                               ready;
  logic [jpm_pkg::TIME_W-1:0]         sample_time;
  logic signed [jpm_pkg::ACC_W-1:0]   accel_value;
  logic                               end_of_run;

  modport source (output valid, output sample_time, output accel_value,
                  output end_of_run, input ready);
  modport sink   (input valid, input sample_time, input accel_value,
                  input end_of_run, output ready);

endinterface

@@ hw/rtl/jpm_out_if.sv @@
// ---------------------------------------------------------------------------
// jpm_out_if
// Result channel: peak and mean jerk with pass and short-run flags.
// ---------------------------------------------------------------------------
interface jpm_out_if;

  logic                        valid;
  logic                        ready;
  logic [jpm_pkg::JERK_W-1:0]  peak_jerk;
  logic [jpm_pkg::JERK_W-1:0]  avg_jerk;
  logic                        within_limit;
  logic                        too_few_points;

  modport source (output valid, output peak_jerk, output avg_jerk,
                  output within_limit, output too_few_points, input ready);
  modport sink   (input valid, input peak_jerk, input avg_jerk,
                  input within_limit, input too_few_points, output ready);

endinterface

@@ hw/rtl/jerk_peak_and_mean_unit.sv @@
// ---------------------------------------------------------------------------
// jerk_peak_and_mean_unit
// Finite-difference jerk over a trajectory run; reports peak, mean and
// pass flag on the last sample. One bit-serial divider serves both the
// per-sample jerk and the final mean.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     sample_time, accel_value, end_of_run
//  out_ch    out  valid/ready     peak_jerk, avg_jerk, within_limit,
//                                 too_few_points
//  cfg_*     in   cfg_wr_en       cfg_wr_data (jerk_limit)
//
//  A sample without a jerk is taken in S_IDLE alone. A sample with a jerk
//  adds one multiply step, 38 divider steps (one quotient bit a cycle), one
//  update. The last sample adds a mean-prep step, plus 48 divider steps when
//  at least one jerk was summed, plus the load of the output register.
//  The output register holds a result until taken; new samples are accepted
//  meanwhile, only a following end of run waits on it.
//  rst_n is synchronous: run state cleared, jerk_limit back to 512.
//
module jerk_peak_and_mean_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  jpm_in_if.sink                     in_ch,
  jpm_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  logic [jpm_pkg::JERK_W-1:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_JDIV  = 3'd2;
  localparam logic [2:0] S_JUPD  = 3'd3;
  localparam logic [2:0] S_MPREP = 3'd4;
  localparam logic [2:0] S_MDIV  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam int TW = jpm_pkg::TIME_W;
  localparam int AW = jpm_pkg::ACC_W;
  localparam int JW = jpm_pkg::JERK_W;
  localparam int SW = jpm_pkg::SUM_W;
  localparam int DW = jpm_pkg::DVD_W;
  localparam int CW = jpm_pkg::CNT_W;
  localparam int MW = jpm_pkg::MAG_W;
  localparam int NW = jpm_pkg::NUM_W;

  // control
  logic [2:0]           state_r, state_nxt;
  logic [1:0]           seen_r, seen_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;
  logic                 few_r, few_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [JW-1:0]        limit_r, limit_nxt;
  // run state
  logic [TW-1:0]        older_r, older_nxt;
  logic [TW-1:0]        newer_r, newer_nxt;
  logic signed [AW-1:0] nacc_r, nacc_nxt;
  logic [JW-1:0]        peak_r, peak_nxt;
  logic [SW-1:0]        sum_r, sum_nxt;
  logic [JW-1:0]        count_r, count_nxt;
  // datapath
  logic [MW-1:0]        mag_r, mag_nxt;
  logic [DW-1:0]        dvd_r, dvd_nxt;
  logic [TW-1:0]        dvs_r, dvs_nxt;
  logic [TW-1:0]        rem_r, rem_nxt;
  logic [JW-1:0]        quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;
  // output payload
  logic [JW-1:0]        o_peak_r, o_peak_nxt;
  logic [JW-1:0]        o_mean_r, o_mean_nxt;
  logic                 o_pass_r, o_pass_nxt;
  logic                 o_few_r, o_few_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 has_jerk;
  logic signed [AW:0]   acc_diff;
  logic [AW:0]          acc_mag;
  logic [NW-1:0]        num;
  logic [TW+1:0]        trial;
  logic                 borrow;
  logic [JW-1:0]        jerk_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // a jerk needs two earlier samples and both time steps strictly positive
  assign has_jerk = (seen_r >= 2'd2) && (newer_r > older_r)
                    && (in_ch.sample_time > newer_r);
  assign acc_diff = {in_ch.accel_value[AW-1], in_ch.accel_value}
                    - {nacc_r[AW-1], nacc_r};
  assign acc_mag  = acc_diff[AW] ? (AW+1)'(0) - $unsigned(acc_diff)
                                 : $unsigned(acc_diff);

  assign num = NW'(mag_r) * NW'(jpm_pkg::JERK_SCALE);

  // one restoring step; dt sum equals t - t_{i-2}, which fits 32 bits
  assign trial  = {1'b0, rem_r, dvd_r[DW-1]} - {2'b00, dvs_r};
  assign borrow = trial[TW+1];

  assign jerk_sat = ovf_r ? '1 : quo_r;

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    few_nxt       = few_r;
    out_valid_nxt = out_valid_r;
    limit_nxt     = limit_r;
    older_nxt     = older_r;
    newer_nxt     = newer_r;
    nacc_nxt      = nacc_r;
    peak_nxt      = peak_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    mag_nxt       = mag_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    o_peak_nxt    = o_peak_r;
    o_mean_nxt    = o_mean_r;
    o_pass_nxt    = o_pass_r;
    o_few_nxt     = o_few_r;

    if (cfg_wr_en) begin
      limit_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt  = in_ch.end_of_run;
          few_nxt   = (seen_r < 2'd2);
          mag_nxt   = acc_mag[MW-1:0];
          dvs_nxt   = in_ch.sample_time - older_r;
          older_nxt = newer_r;
          newer_nxt = in_ch.sample_time;
          nacc_nxt  = in_ch.accel_value;
          if (seen_r != 2'd3) begin
            seen_nxt = seen_r + 2'd1;
          end
          if (has_jerk) begin
            state_nxt = S_MUL;
          end else if (in_ch.end_of_run) begin
            state_nxt = S_MPREP;
          end
        end
      end
      S_MUL: begin
        dvd_nxt   = {num, (DW - NW)'(0)};
        rem_nxt   = '0;
        quo_nxt   = '0;
        ovf_nxt   = 1'b0;
        cnt_nxt   = jpm_pkg::JERK_DIV_STEPS;
        state_nxt = S_JDIV;
      end
      S_JDIV, S_MDIV: begin
        rem_nxt = borrow ? {rem_r[TW-2:0], dvd_r[DW-1]} : trial[TW-1:0];
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        quo_nxt = {quo_r[JW-2:0], !borrow};
        ovf_nxt = ovf_r | quo_r[JW-1];
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = (state_r == S_JDIV) ? S_JUPD : S_EMIT;
        end
      end
      S_JUPD: begin
        if (jerk_sat > peak_r) begin
          peak_nxt = jerk_sat;
        end
        if (count_r != jpm_pkg::MAX_RUN_SAMPLES) begin
          sum_nxt   = sum_r + SW'(jerk_sat);
          count_nxt = count_r + JW'(1);
        end
        state_nxt = last_r ? S_MPREP : S_IDLE;
      end
      S_MPREP: begin
        quo_nxt = '0;
        if (few_r || count_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          dvd_nxt   = sum_r;
          dvs_nxt   = TW'(count_r);
          rem_nxt   = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = jpm_pkg::MEAN_DIV_STEPS;
          state_nxt = S_MDIV;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_few_nxt     = few_r;
          o_peak_nxt    = few_r ? '0 : peak_r;
          o_mean_nxt    = few_r ? '0 : quo_r;
          o_pass_nxt    = few_r || (peak_r <= limit_r);
          seen_nxt      = '0;
          older_nxt     = '0;
          newer_nxt     = '0;
          nacc_nxt      = '0;
          peak_nxt      = '0;
          sum_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      few_r       <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= jpm_pkg::LIMIT_RESET;
      older_r     <= '0;
      newer_r     <= '0;
      nacc_r      <= '0;
      peak_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      few_r       <= few_nxt;
      out_valid_r <= out_valid_nxt;
      limit_r     <= limit_nxt;
      older_r     <= older_nxt;
      newer_r     <= newer_nxt;
      nacc_r      <= nacc_nxt;
      peak_r      <= peak_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    dvd_r    <= dvd_nxt;
    dvs_r    <= dvs_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    ovf_r    <= ovf_nxt;
    o_peak_r <= o_peak_nxt;
    o_mean_r <= o_mean_nxt;
    o_pass_r <= o_pass_nxt;
    o_few_r  <= o_few_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_jerk      = o_peak_r;
  assign out_ch.avg_jerk       = o_mean_r;
  assign out_ch.within_limit   = o_pass_r;
  assign out_ch.too_few_points = o_few_r;

  // a result only appears after the end-of-run load
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside end of run");

  // run state is cleared once a result is loaded
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (seen_r == '0 && count_r == '0
      && peak_r == '0 && sum_r == '0))
    else $error("run state not cleared after result");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_JDIV || state_r == S_MDIV) |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

endmodule

@@ tb/tb_jerk_peak_and_mean_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_jerk_peak_and_mean_unit
// Drives trajectory runs into the jerk unit and checks every run summary
// against a cycle-free predictor. A short table of hand-picked samples comes
// first, then random runs under three back-pressure mixes and a long output
// stall, with the jerk limit rewritten between phases.
// ---------------------------------------------------------------------------
module tb_jerk_peak_and_mean_unit;

  localparam int          DRAIN_CYCLES  = 120;
  localparam longint      CYCLE_LIMIT   = 1_000_000;
  localparam logic [23:0] JERK_MAX      = 24'hFF_FFFF;
  localparam logic [23:0] COUNT_MAX     = 24'hFF_FFFF;

  typedef struct packed {
    logic [jpm_pkg::TIME_W-1:0]       stamp;
    logic signed [jpm_pkg::ACC_W-1:0] accel;
    logic                             last;
  } sample_t;

  typedef struct packed {
    logic [jpm_pkg::JERK_W-1:0] peak;
    logic [jpm_pkg::JERK_W-1:0] mean;
    logic                       pass_flag;
    logic                       few;
  } summary_t;

  typedef struct {
    sample_t  smp;
    bit       typed;
    summary_t want;
  } directed_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [jpm_pkg::JERK_W-1:0]  cfg_wr_data;

  jpm_in_if  in_ch ();
  jpm_out_if out_ch ();

  jerk_peak_and_mean_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state, mirrors the run state of the unit
  logic [1:0]                       run_len      = '0;
  logic [jpm_pkg::TIME_W-1:0]       stamp_older  = '0;
  logic [jpm_pkg::TIME_W-1:0]       stamp_newer  = '0;
  logic signed [jpm_pkg::ACC_W-1:0] accel_newer  = '0;
  logic [jpm_pkg::JERK_W-1:0]       peak_hold    = '0;
  logic [jpm_pkg::SUM_W-1:0]        abs_jerk_sum = '0;
  logic [jpm_pkg::JERK_W-1:0]       summed_jerks = '0;
  logic [jpm_pkg::JERK_W-1:0]       limit_shadow = jpm_pkg::LIMIT_RESET;

  summary_t      pending_summaries[$];
  directed_row_t directed_rows[$];
  int            fail_count    = 0;
  int            items_sent    = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_req      = 0;
  longint        cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL jerk_peak_and_mean_unit");
      $finish;
    end
  end

  // Returns 1 when the sample closes a run; res then holds the summary.
  function automatic bit predict_summary(input sample_t smp, output summary_t res);
    logic [63:0] step_sum;
    logic [63:0] swing;
    logic [63:0] jerk;
    logic [63:0] mean_full;
    int          delta;
    bit          short_run;
    res = '0;
    if (run_len >= 2 && stamp_newer > stamp_older && smp.stamp > stamp_newer) begin
      step_sum = 64'(stamp_newer - stamp_older) + 64'(smp.stamp - stamp_newer);
      delta    = int'($signed(smp.accel)) - int'(accel_newer);
      swing    = 64'(delta < 0 ? -delta : delta);
      // dividing by half the step sum, with us -> s
      jerk     = (swing * 64'd2_000_000) / step_sum;
      if (jerk > 64'(JERK_MAX)) jerk = 64'(JERK_MAX);
      if (jerk[23:0] > peak_hold) peak_hold = jerk[23:0];
      if (summed_jerks < COUNT_MAX) begin
        abs_jerk_sum = abs_jerk_sum + jerk[jpm_pkg::SUM_W-1:0];
        summed_jerks = summed_jerks + 24'd1;
      end
    end
    short_run   = run_len < 2;
    stamp_older = stamp_newer;
    stamp_newer = smp.stamp;
    accel_newer = smp.accel;
    if (run_len < 3) run_len = run_len + 2'd1;
    if (!smp.last) return 1'b0;

    if (short_run) begin
      res.pass_flag = 1'b1;
      res.few       = 1'b1;
    end else begin
      mean_full     = (summed_jerks != 0) ?
                      64'(abs_jerk_sum) / 64'(summed_jerks) : 64'd0;
      res.peak      = peak_hold;
      res.mean      = mean_full[23:0];
      res.pass_flag = peak_hold <= limit_shadow;
      res.few       = 1'b0;
    end
    run_len      = '0;
    stamp_older  = '0;
    stamp_newer  = '0;
    accel_newer  = '0;
    peak_hold    = '0;
    abs_jerk_sum = '0;
    summed_jerks = '0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [31:0] stamp, input int acc, input bit last,
                                  input bit typed, input logic [23:0] peak,
                                  input logic [23:0] mean, input bit pass_flag,
                                  input bit few);
    directed_row_t row;
    row.smp.stamp      = stamp;
    row.smp.accel      = 16'(acc);
    row.smp.last       = last;
    row.typed          = typed;
    row.want.peak      = peak;
    row.want.mean      = mean;
    row.want.pass_flag = pass_flag;
    row.want.few       = few;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic send_sample(input sample_t smp, input bit typed, input summary_t typed_want);
    summary_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_time <= smp.stamp;
    in_ch.accel_value <= smp.accel;
    in_ch.end_of_run  <= smp.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (predict_summary(smp, predicted))
      pending_summaries.insert(pending_summaries.size(), typed ? typed_want : predicted);
  endtask

  // One trajectory: mostly smooth runs, some with full-scale swings over
  // microsecond steps, some with stalled, reversed or huge time steps.
  task automatic send_random_run(input bit short_only);
    int          run_items;
    int          pick;
    int          style;
    int          acc;
    int          k;
    sample_t     smp;
    logic [31:0] stamp;
    pick = $urandom_range(99);
    if (short_only)     run_items = $urandom_range(1, 3);
    else if (pick < 10) run_items = $urandom_range(1, 2);
    else if (pick < 90) run_items = $urandom_range(3, 8);
    else                run_items = $urandom_range(9, 40);
    style = $urandom_range(99);
    stamp = (style < 85) ? $urandom_range(0, 32'hF000_0000) : $urandom();
    acc   = int'($urandom_range(0, 65535)) - 32768;
    for (k = 0; k < run_items; k++) begin
      smp.stamp = stamp;
      smp.accel = 16'(acc);
      smp.last  = (k == run_items - 1);
      send_sample(smp, 1'b0, '0);
      if (style < 70) begin
        stamp = stamp + $urandom_range(1000, 100000);
        acc   = acc + int'($urandom_range(0, 600)) - 300;
        if (acc > 32767)  acc = 32767;
        if (acc < -32768) acc = -32768;
      end else if (style < 85) begin
        stamp = stamp + $urandom_range(1, 3);
        acc   = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        case ($urandom_range(3))
          0:       stamp = stamp - $urandom_range(0, 5);
          1:       stamp = stamp + $urandom();
          default: stamp = stamp + $urandom_range(0, 50000);
        endcase
        acc = int'($urandom_range(0, 65535)) - 32768;
      end
    end
  endtask

  // Drop valid, let every summary come back and the divider go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_shadow = value;
  endtask

  // result sink; a long hold lets the output register fill and back up the input
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : summary_check
    summary_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_summaries.size() == 0) begin
        $error("unexpected result: peak_jerk %0d avg_jerk %0d",
               out_ch.peak_jerk, out_ch.avg_jerk);
        fail_count++;
      end else begin
        want = pending_summaries.pop_front();
        if (out_ch.peak_jerk !== want.peak) begin
          $error("peak_jerk: expected %0d, actual %0d", want.peak, out_ch.peak_jerk);
          fail_count++;
        end
        if (out_ch.avg_jerk !== want.mean) begin
          $error("avg_jerk: expected %0d, actual %0d", want.mean, out_ch.avg_jerk);
          fail_count++;
        end
        if (out_ch.within_limit !== want.pass_flag) begin
          $error("within_limit: expected %0d, actual %0d", want.pass_flag,
                 out_ch.within_limit);
          fail_count++;
        end
        if (out_ch.too_few_points !== want.few) begin
          $error("too_few_points: expected %0d, actual %0d", want.few, out_ch.too_few_points);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int k;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.sample_time <= '0;
    in_ch.accel_value <= '0;
    in_ch.end_of_run  <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 88;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limit is still at its reset value of 512 here
    // lone sample: too few points
    add_row(32'd0, 0, 1, 1, 24'd0, 24'd0, 1, 1);
    // two samples at the acceleration extremes: still too few
    add_row(32'd100, 32767, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd200, -32768, 1, 1, 24'd0, 24'd0, 1, 1);
    // full-scale swing over 1 us steps saturates peak and mean
    add_row(32'd0, -32768, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd1, 32767, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd2, -32768, 1, 1, JERK_MAX, JERK_MAX, 0, 0);
    // repeated timestamp: no jerk at all
    add_row(32'd500, 10, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd500, 20, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd600, 30, 1, 1, 24'd0, 24'd0, 1, 0);
    // time running backward at the top of the range, no wrap allowed
    add_row(32'hFFFF_FFFF, 0, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'hFFFF_FFFE, 1, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'hFFFF_FFFF, 2, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd0, 3, 1, 1, 24'd0, 24'd0, 1, 0);
    // 1 m/s^2 over a 1 s mean step: jerk 256, under the limit
    add_row(32'd0, 0, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd1_000_000, 0, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd2_000_000, 256, 1, 1, 24'd256, 24'd256, 1, 0);
    // one LSB over 1 ms: jerk 1000, above the limit
    add_row(32'd0, 0, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd1000, 0, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd2000, 1, 1, 1, 24'd1000, 24'd1000, 0, 0);
    // widest possible time-step sum
    add_row(32'd0, 32767, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd1, -32768, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'hFFFF_FFFF, 32767, 1, 0, 24'd0, 24'd0, 0, 0);
    // two jerks: peak differs from mean
    add_row(32'd10_000, 0, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd20_000, 100, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd40_000, -50, 0, 0, 24'd0, 24'd0, 0, 0);
    add_row(32'd45_000, 300, 1, 0, 24'd0, 24'd0, 0, 0);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);

    settle();
    write_limit(24'($urandom_range(0, 60000)));
    while (items_sent < 170) send_random_run(1'b0);

    settle();
    send_idle_pct = 88;
    recv_idle_pct = 23;
    write_limit(24'd0);
    while (items_sent < 340) send_random_run(1'b0);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(JERK_MAX);
    hold_req = 1;
    for (k = 0; k < 8; k++) send_random_run(1'b1);
    while (items_sent < 420) send_random_run(1'b0);

    settle();
    write_limit(24'($urandom_range(0, 200000)));
    while (items_sent < 500) send_random_run(1'b0);

    settle();
    if (fail_count == 0) begin
      $display("PASS jerk_peak_and_mean_unit");
    end else begin
      $display("FAIL jerk_peak_and_mean_unit");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/jpm_pkg.sv
hw/rtl/jpm_in_if.sv
hw/rtl/jpm_out_if.sv
hw/rtl/jerk_peak_and_mean_unit.sv
tb/tb_jerk_peak_and_mean_unit.sv
